// ----- hw/rtl/thumb_instruction_decoder_top_assert.svh -----
// ---------------------------------------------------------------------------
// Thumb decoder assertion macros
// Concurrent check wrappers; they compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef THUMB_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define THUMB_INSTRUCTION_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tid check failed");

// next-cycle implication
`define TID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tid check failed");

`else

`define TID_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TID_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/tid_pkg.sv -----
// ---------------------------------------------------------------------------
// tid_pkg
// Operation codes, encoding forms, pattern table and result type shared by
// the Thumb decoder modules.
// ---------------------------------------------------------------------------
package tid_pkg;

    typedef enum logic [6:0] {
        OP_UDF = 7'd0, OP_ADC, OP_ADDI, OP_ADD, OP_ADR, OP_AND, OP_ASRI, OP_ASR,
        OP_SVC, OP_BCOND, OP_BIC, OP_BKPT, OP_BLX, OP_BX, OP_CMN, OP_CMP, OP_EOR,
        OP_LDM, OP_LDRI, OP_LDRL, OP_LDR, OP_LDRBI, OP_LDRB, OP_LDRHI, OP_LDRH,
        OP_LDRSB, OP_LDRSH, OP_LSLI, OP_LSL, OP_LSRI, OP_LSR, OP_MOV, OP_MUL,
        OP_MVN, OP_NOP, OP_ORR, OP_POP, OP_PUSH, OP_REV, OP_REV16, OP_REVSH,
        OP_ROR, OP_RSB, OP_SBC, OP_SEV, OP_STM, OP_STRI, OP_STR, OP_STRBI, OP_STRB,
        OP_STRHI, OP_STRH, OP_SUBI, OP_SUB, OP_SXTB, OP_SXTH, OP_TST, OP_UXTB,
        OP_UXTH, OP_WFE, OP_WFI, OP_YIELD, OP_DMB, OP_DSB, OP_ISB, OP_MRS, OP_MSR,
        OP_BL
    } t_op;

    // operand layout of a 16-bit encoding
    typedef enum logic [4:0] {
        F_NONE, F_DP, F_R3, F_I3, F_SHI, F_SHI32, F_LSI, F_R8I8, F_N8I8, F_DN8I8,
        F_SPI8, F_SPI7, F_HI_DNM, F_HI_NM, F_HI_DM, F_CMPLO, F_DM, F_SPR, F_SPR2,
        F_M4, F_I8, F_LIST, F_PUSH, F_POP, F_BC, F_B
    } t_form;

    typedef struct packed {
        logic [15:0] mask;
        logic [15:0] match;
        t_op         op;
        t_form       form;
        logic        flags;
    } t_pat;

    typedef struct packed {
        t_op         op;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [3:0]  rm;
        logic [24:0] imm;
        logic        sf;
        logic [15:0] spec;
    } t_dec;

    localparam t_dec DEC_ZERO = '{op: OP_UDF, default: '0};

    localparam logic [3:0]  REG_SP      = 4'd13;
    localparam logic [15:0] COND_AL     = 16'd14;
    localparam logic [24:0] SHIFT_32    = 25'd32;

    // 32-bit encodings
    localparam logic [31:0] BAR_MASK    = 32'hFFFF_FFF0;
    localparam logic [31:0] DMB_MATCH   = 32'hF3BF_8F50;
    localparam logic [31:0] DSB_MATCH   = 32'hF3BF_8F40;
    localparam logic [31:0] ISB_MATCH   = 32'hF3BF_8F60;
    localparam logic [31:0] MRS_MASK    = 32'hFFFF_F000;
    localparam logic [31:0] MRS_MATCH   = 32'hF3EF_8000;
    localparam logic [31:0] MSR_MASK    = 32'hFFF0_FF00;
    localparam logic [31:0] MSR_MATCH   = 32'hF380_8800;
    localparam logic [31:0] UDFW_MASK   = 32'hFFF0_F000;
    localparam logic [31:0] UDFW_MATCH  = 32'hF7F0_A000;
    localparam logic [31:0] BL_MASK     = 32'hF800_D000;
    localparam logic [31:0] BL_MATCH    = 32'hF000_D000;

    localparam int NARROW_N     = 77;
    localparam int NARROW_IDX_W = $clog2(NARROW_N);

    // ordered: first hit wins
    localparam t_pat NARROW_TAB [NARROW_N] = '{
        '{16'hFFC0, 16'h4140, OP_ADC,   F_DP,     1'b1},
        '{16'hFE00, 16'h1C00, OP_ADDI,  F_I3,     1'b1},
        '{16'hF800, 16'h3000, OP_ADDI,  F_DN8I8,  1'b1},
        '{16'hFF78, 16'h4468, OP_ADD,   F_SPR,    1'b0},
        '{16'hFF87, 16'h4485, OP_ADD,   F_SPR2,   1'b0},
        '{16'hFE00, 16'h1800, OP_ADD,   F_R3,     1'b1},
        '{16'hFF00, 16'h4400, OP_ADD,   F_HI_DNM, 1'b0},
        '{16'hF800, 16'hA800, OP_ADDI,  F_SPI8,   1'b0},
        '{16'hFF80, 16'hB000, OP_ADDI,  F_SPI7,   1'b0},
        '{16'hF800, 16'hA000, OP_ADR,   F_R8I8,   1'b0},
        '{16'hFFC0, 16'h4000, OP_AND,   F_DP,     1'b1},
        '{16'hF800, 16'h1000, OP_ASRI,  F_SHI32,  1'b1},
        '{16'hFFC0, 16'h4100, OP_ASR,   F_DP,     1'b1},
        '{16'hFF00, 16'hDF00, OP_SVC,   F_I8,     1'b0},
        '{16'hFF00, 16'hDE00, OP_UDF,   F_NONE,   1'b0},
        '{16'hF000, 16'hD000, OP_BCOND, F_BC,     1'b0},
        '{16'hF800, 16'hE000, OP_BCOND, F_B,      1'b0},
        '{16'hFFC0, 16'h4380, OP_BIC,   F_DP,     1'b1},
        '{16'hFF00, 16'hBE00, OP_BKPT,  F_I8,     1'b0},
        '{16'hFF80, 16'h4780, OP_BLX,   F_M4,     1'b0},
        '{16'hFF80, 16'h4700, OP_BX,    F_M4,     1'b0},
        '{16'hFFC0, 16'h42C0, OP_CMN,   F_DP,     1'b1},
        '{16'hF800, 16'h2800, OP_CMP,   F_N8I8,   1'b1},
        '{16'hFFC0, 16'h4280, OP_CMP,   F_CMPLO,  1'b1},
        '{16'hFF00, 16'h4500, OP_CMP,   F_HI_NM,  1'b1},
        '{16'hFFC0, 16'h4040, OP_EOR,   F_DP,     1'b1},
        '{16'hF800, 16'hC800, OP_LDM,   F_LIST,   1'b0},
        '{16'hF800, 16'h6800, OP_LDRI,  F_LSI,    1'b0},
        '{16'hF800, 16'h9800, OP_LDRI,  F_SPI8,   1'b0},
        '{16'hF800, 16'h4800, OP_LDRL,  F_R8I8,   1'b0},
        '{16'hFE00, 16'h5800, OP_LDR,   F_R3,     1'b0},
        '{16'hF800, 16'h7800, OP_LDRBI, F_LSI,    1'b0},
        '{16'hFE00, 16'h5C00, OP_LDRB,  F_R3,     1'b0},
        '{16'hF800, 16'h8800, OP_LDRHI, F_LSI,    1'b0},
        '{16'hFE00, 16'h5A00, OP_LDRH,  F_R3,     1'b0},
        '{16'hFE00, 16'h5600, OP_LDRSB, F_R3,     1'b0},
        '{16'hFE00, 16'h5E00, OP_LDRSH, F_R3,     1'b0},
        '{16'hFFC0, 16'h0000, OP_MOV,   F_DM,     1'b1},
        '{16'hF800, 16'h0000, OP_LSLI,  F_SHI,    1'b1},
        '{16'hFFC0, 16'h4080, OP_LSL,   F_DP,     1'b1},
        '{16'hF800, 16'h0800, OP_LSRI,  F_SHI32,  1'b1},
        '{16'hFFC0, 16'h40C0, OP_LSR,   F_DP,     1'b1},
        '{16'hF800, 16'h2000, OP_MOV,   F_R8I8,   1'b1},
        '{16'hFF00, 16'h4600, OP_MOV,   F_HI_DM,  1'b0},
        '{16'hFFC0, 16'h4340, OP_MUL,   F_DP,     1'b1},
        '{16'hFFC0, 16'h43C0, OP_MVN,   F_DP,     1'b1},
        '{16'hFFFF, 16'hBF00, OP_NOP,   F_NONE,   1'b0},
        '{16'hFFC0, 16'h4300, OP_ORR,   F_DP,     1'b1},
        '{16'hFE00, 16'hBC00, OP_POP,   F_POP,    1'b0},
        '{16'hFE00, 16'hB400, OP_PUSH,  F_PUSH,   1'b0},
        '{16'hFFC0, 16'hBA00, OP_REV,   F_DM,     1'b0},
        '{16'hFFC0, 16'hBA40, OP_REV16, F_DM,     1'b0},
        '{16'hFFC0, 16'hBAC0, OP_REVSH, F_DM,     1'b0},
        '{16'hFFC0, 16'h41C0, OP_ROR,   F_DP,     1'b1},
        '{16'hFFC0, 16'h4240, OP_RSB,   F_DP,     1'b1},
        '{16'hFFC0, 16'h4180, OP_SBC,   F_DP,     1'b1},
        '{16'hFFFF, 16'hBF40, OP_SEV,   F_NONE,   1'b0},
        '{16'hF800, 16'hC000, OP_STM,   F_LIST,   1'b0},
        '{16'hF800, 16'h6000, OP_STRI,  F_LSI,    1'b0},
        '{16'hF800, 16'h9000, OP_STRI,  F_SPI8,   1'b0},
        '{16'hFE00, 16'h5000, OP_STR,   F_R3,     1'b0},
        '{16'hF800, 16'h7000, OP_STRBI, F_LSI,    1'b0},
        '{16'hFE00, 16'h5400, OP_STRB,  F_R3,     1'b0},
        '{16'hF800, 16'h8000, OP_STRHI, F_LSI,    1'b0},
        '{16'hFE00, 16'h5200, OP_STRH,  F_R3,     1'b0},
        '{16'hFE00, 16'h1E00, OP_SUBI,  F_I3,     1'b1},
        '{16'hF800, 16'h3800, OP_SUBI,  F_DN8I8,  1'b1},
        '{16'hFE00, 16'h1A00, OP_SUB,   F_R3,     1'b1},
        '{16'hFF80, 16'hB080, OP_SUB,   F_SPI7,   1'b0},
        '{16'hFFC0, 16'hB240, OP_SXTB,  F_DM,     1'b0},
        '{16'hFFC0, 16'hB200, OP_SXTH,  F_DM,     1'b0},
        '{16'hFFC0, 16'h4200, OP_TST,   F_DP,     1'b1},
        '{16'hFFC0, 16'hB2C0, OP_UXTB,  F_DM,     1'b0},
        '{16'hFFC0, 16'hB280, OP_UXTH,  F_DM,     1'b0},
        '{16'hFFFF, 16'hBF20, OP_WFE,   F_NONE,   1'b0},
        '{16'hFFFF, 16'hBF30, OP_WFI,   F_NONE,   1'b0},
        '{16'hFFFF, 16'hBF10, OP_YIELD, F_NONE,   1'b0}
    };

endpackage

// ----- hw/rtl/tid_narrow_dec.sv -----
// ---------------------------------------------------------------------------
// tid_narrow_dec
// 16-bit Thumb decode: priority match against the pattern table, then
// operand extraction by encoding form.
// ---------------------------------------------------------------------------
module tid_narrow_dec
    import tid_pkg::*;
(
    input  logic [15:0] i_instr,
    output t_dec        o_dec
);

    logic [NARROW_N-1:0]     hit_vec;
    logic                    hit;
    logic [NARROW_IDX_W-1:0] sel;
    t_pat                    pat;
    logic [2:0]              r0, r3, r6, r8;
    logic [3:0]              n4, m4;
    logic [4:0]              i5;
    logic [7:0]              i8;

    always_comb begin
        for (int i = 0; i < NARROW_N; i++) begin
            hit_vec[i] = (i_instr & NARROW_TAB[i].mask) == NARROW_TAB[i].match;
        end
    end

    // lowest index wins
    always_comb begin
        hit = 1'b0;
        sel = '0;
        for (int i = NARROW_N - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit = 1'b1;
                sel = NARROW_IDX_W'(i);
            end
        end
    end

    assign pat = NARROW_TAB[sel];
    assign r0  = i_instr[2:0];
    assign r3  = i_instr[5:3];
    assign r6  = i_instr[8:6];
    assign r8  = i_instr[10:8];
    assign n4  = {i_instr[7], i_instr[2:0]};
    assign m4  = i_instr[6:3];
    assign i5  = i_instr[10:6];
    assign i8  = i_instr[7:0];

    always_comb begin
        o_dec = DEC_ZERO;
        if (hit) begin
            o_dec.op = pat.op;
            o_dec.sf = pat.flags;
            case (pat.form)
                F_DP: begin
                    o_dec.rd = {1'b0, r0};
                    o_dec.rn = {1'b0, r0};
                    o_dec.rm = {1'b0, r3};
                end
                F_R3: begin
                    o_dec.rd = {1'b0, r0};
                    o_dec.rn = {1'b0, r3};
                    o_dec.rm = {1'b0, r6};
                end
                F_I3: begin
                    o_dec.rd  = {1'b0, r0};
                    o_dec.rn  = {1'b0, r3};
                    o_dec.imm = 25'(r6);
                end
                F_SHI: begin
                    o_dec.rd  = {1'b0, r0};
                    o_dec.rm  = {1'b0, r3};
                    o_dec.imm = 25'(i5);
                end
                F_SHI32: begin
                    // encoded zero shift means 32
                    o_dec.rd  = {1'b0, r0};
                    o_dec.rm  = {1'b0, r3};
                    o_dec.imm = (i5 == '0) ? SHIFT_32 : 25'(i5);
                end
                F_LSI: begin
                    o_dec.rd  = {1'b0, r0};
                    o_dec.rn  = {1'b0, r3};
                    o_dec.imm = 25'(i5);
                end
                F_R8I8: begin
                    o_dec.rd  = {1'b0, r8};
                    o_dec.imm = 25'(i8);
                end
                F_N8I8: begin
                    o_dec.rn  = {1'b0, r8};
                    o_dec.imm = 25'(i8);
                end
                F_DN8I8: begin
                    o_dec.rd  = {1'b0, r8};
                    o_dec.rn  = {1'b0, r8};
                    o_dec.imm = 25'(i8);
                end
                F_SPI8: begin
                    o_dec.rd  = {1'b0, r8};
                    o_dec.rn  = REG_SP;
                    o_dec.imm = 25'(i8);
                end
                F_SPI7: begin
                    o_dec.rd  = REG_SP;
                    o_dec.rn  = REG_SP;
                    o_dec.imm = 25'(i_instr[6:0]);
                end
                F_HI_DNM: begin
                    o_dec.rd = n4;
                    o_dec.rn = n4;
                    o_dec.rm = m4;
                end
                F_HI_NM: begin
                    o_dec.rn = n4;
                    o_dec.rm = m4;
                end
                F_HI_DM: begin
                    o_dec.rd = n4;
                    o_dec.rm = m4;
                end
                F_CMPLO: begin
                    o_dec.rn = {1'b0, r0};
                    o_dec.rm = {1'b0, r3};
                end
                F_DM: begin
                    o_dec.rd = {1'b0, r0};
                    o_dec.rm = {1'b0, r3};
                end
                F_SPR: begin
                    o_dec.rd = n4;
                    o_dec.rm = n4;
                    o_dec.rn = REG_SP;
                end
                F_SPR2: begin
                    o_dec.rd = REG_SP;
                    o_dec.rn = REG_SP;
                    o_dec.rm = m4;
                end
                F_M4: begin
                    o_dec.rm = m4;
                end
                F_I8: begin
                    o_dec.imm = 25'(i8);
                end
                F_LIST: begin
                    o_dec.rn   = {1'b0, r8};
                    o_dec.spec = 16'(i8);
                end
                F_PUSH: begin
                    // LR bit lands in bit 14
                    o_dec.spec = {1'b0, i_instr[8], 6'b0, i8};
                end
                F_POP: begin
                    // PC bit lands in bit 15
                    o_dec.spec = {i_instr[8], 7'b0, i8};
                end
                F_BC: begin
                    o_dec.imm  = {{16{i8[7]}}, i8, 1'b0};
                    o_dec.spec = {12'b0, i_instr[11:8]};
                end
                F_B: begin
                    o_dec.imm  = {{13{i_instr[10]}}, i_instr[10:0], 1'b0};
                    o_dec.spec = COND_AL;
                end
                default: begin
                    o_dec.rd = '0;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/tid_wide_dec.sv -----
// ---------------------------------------------------------------------------
// tid_wide_dec
// 32-bit Thumb decode: barriers, MRS, MSR, permanent UDF and BL.
// ---------------------------------------------------------------------------
module tid_wide_dec
    import tid_pkg::*;
(
    input  logic [31:0] i_instr,
    output t_dec        o_dec
);

    logic [15:0] hi, lo;
    logic        s, i1, i2;

    assign hi = i_instr[31:16];
    assign lo = i_instr[15:0];
    assign s  = hi[10];
    assign i1 = ~(lo[13] ^ s);
    assign i2 = ~(lo[11] ^ s);

    always_comb begin
        o_dec = DEC_ZERO;
        if ((i_instr & BAR_MASK) == DMB_MATCH) begin
            o_dec.op = OP_DMB;
        end else if ((i_instr & BAR_MASK) == DSB_MATCH) begin
            o_dec.op = OP_DSB;
        end else if ((i_instr & BAR_MASK) == ISB_MATCH) begin
            o_dec.op = OP_ISB;
        end else if ((i_instr & MRS_MASK) == MRS_MATCH) begin
            o_dec.op   = OP_MRS;
            o_dec.rd   = lo[11:8];
            o_dec.spec = {8'b0, lo[7:0]};
        end else if ((i_instr & MSR_MASK) == MSR_MATCH) begin
            o_dec.op   = OP_MSR;
            o_dec.rn   = hi[3:0];
            o_dec.spec = {8'b0, lo[7:0]};
        end else if ((i_instr & UDFW_MASK) == UDFW_MATCH) begin
            o_dec.op = OP_UDF;
        end else if ((i_instr & BL_MASK) == BL_MATCH) begin
            o_dec.op  = OP_BL;
            o_dec.imm = {s, i1, i2, hi[9:0], lo[10:0], 1'b0};
        end
    end

endmodule

// ----- hw/rtl/thumb_instruction_decoder_top.sv -----
// ---------------------------------------------------------------------------
// thumb_instruction_decoder_top
// ARMv6-M Thumb decoder: one instruction in, one decoded request out. Takes a
// new instruction every cycle unless stalled; each request passes through the
// input register and then the result register, with the whole 16-bit table
// match and 32-bit match done in the single combinational pass between them.
// The input side stalls only when both registers hold requests the output
// side has not taken. Unmatched encodings decode as UDF (operation 0) with
// all other fields zero.
// ---------------------------------------------------------------------------
`include "thumb_instruction_decoder_top_assert.svh"

module thumb_instruction_decoder_top
    import tid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] instruction
    input  logic        i_s_axis_tuser,   // [0] is_wide
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [6:0] operation, [10:7] dest_reg, [14:11] first_reg, [18:15] second_reg,
    // [43:19] immediate, [44] sets_flags, [60:45] specific, [63:61] zero
    output logic [63:0] o_m_axis_tdata
);

    logic        r_in_valid;
    logic [31:0] r_instr;
    logic        r_wide;
    logic        r_out_valid;
    t_dec        r_out;
    t_dec        n_out;
    t_dec        narrow_dec, wide_dec;
    logic        out_load, in_load;

    assign out_load        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || out_load;
    assign in_load         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_instr <= i_s_axis_tdata;
            r_wide  <= i_s_axis_tuser;
        end
    end

    tid_narrow_dec u_narrow (
        .i_instr (r_instr[15:0]),
        .o_dec   (narrow_dec)
    );

    tid_wide_dec u_wide (
        .i_instr (r_instr),
        .o_dec   (wide_dec)
    );

    assign n_out = r_wide ? wide_dec : narrow_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b0, r_out.spec, r_out.sf, r_out.imm, r_out.rm,
                              r_out.rn, r_out.rd, r_out.op};

    // an empty result register never blocks the input side
    `TID_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, o_s_axis_tready)
    // an accepted request is held in the input register next cycle
    `TID_ASSERT_NXT(a_accept_lands, i_clk, i_rst_n, in_load, r_in_valid)
    // flag-setting decodes only come from the 16-bit table
    `TID_ASSERT_IMP(a_wide_no_flags, i_clk, i_rst_n, r_out_valid && r_out.sf, r_out.op < OP_DMB)

endmodule

// ----- dv/thumb_decode_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// thumb_decode_checker
// Watches both stream channels of the Thumb decoder. Every accepted request
// is decoded here independently, and the expected result is queued. Every
// accepted result is compared field by field with the oldest queued one.
// The failure count and progress counters go back to the testbench top.
// ---------------------------------------------------------------------------
module thumb_decode_checker
    import tid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] instruction
    input  logic        i_s_tuser,   // [0] is_wide
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [6:0] operation, [10:7] dest_reg, [14:11] first_reg, [18:15] second_reg,
    // [43:19] immediate, [44] sets_flags, [60:45] specific, [63:61] zero
    input  logic [63:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_requests,
    output int          o_wide_requests,
    output int          o_results,
    output int          o_ops_seen
);

    localparam logic [3:0]  SP_NUM      = 4'd13;
    localparam logic [15:0] COND_ALWAYS = 16'd14;

    typedef struct packed {
        t_op         op;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [3:0]  rm;
        logic [24:0] imm;
        logic        sf;
        logic [15:0] spec;
    } decode_t;

    typedef struct packed {
        t_op   op;
        t_form form;
        logic  sf;
    } pattern_t;

    typedef struct {
        logic [31:0] instr;
        logic        wide;
        decode_t     want;
    } decode_req_t;

    decode_req_t pending_decodes[$];
    decode_req_t cur;
    bit          ops_hit [128];
    int          fail_total    = 0;
    int          request_total = 0;
    int          wide_total    = 0;
    int          result_total  = 0;
    int          ops_total     = 0;

    function automatic decode_t decode_thumb(logic [31:0] w, logic wide);
        decode_t     d;
        pattern_t    hit;
        logic [15:0] h;
        logic [3:0]  r0, r3, r6, r8, n4, m4;
        logic [24:0] i5, i8;
        logic        s, i1, i2;
        d = '0;
        if (wide) begin
            if ((w & 32'hFFFF_FFF0) == 32'hF3BF_8F50) begin
                d.op = OP_DMB;
            end else if ((w & 32'hFFFF_FFF0) == 32'hF3BF_8F40) begin
                d.op = OP_DSB;
            end else if ((w & 32'hFFFF_FFF0) == 32'hF3BF_8F60) begin
                d.op = OP_ISB;
            end else if ((w & 32'hFFFF_F000) == 32'hF3EF_8000) begin
                d.op   = OP_MRS;
                d.rd   = w[11:8];
                d.spec = {8'b0, w[7:0]};
            end else if ((w & 32'hFFF0_FF00) == 32'hF380_8800) begin
                d.op   = OP_MSR;
                d.rn   = w[19:16];
                d.spec = {8'b0, w[7:0]};
            end else if ((w & 32'hFFF0_F000) == 32'hF7F0_A000) begin
                d.op = OP_UDF;
            end else if ((w & 32'hF800_D000) == 32'hF000_D000) begin
                // I1/I2 = NOT(J xor S); J1 at bit 13, J2 at bit 11
                s     = w[26];
                i1    = ~(w[13] ^ s);
                i2    = ~(w[11] ^ s);
                d.op  = OP_BL;
                d.imm = {s, i1, i2, w[25:16], w[10:0], 1'b0};
            end
            return d;
        end

        h = w[15:0];
        // ordered table, first hit wins
        casez (h)
            16'b0100_0001_01??_????: hit = '{OP_ADC,   F_DP,     1'b1};
            16'b0001_110?_????_????: hit = '{OP_ADDI,  F_I3,     1'b1};
            16'b0011_0???_????_????: hit = '{OP_ADDI,  F_DN8I8,  1'b1};
            16'b0100_0100_?110_1???: hit = '{OP_ADD,   F_SPR,    1'b0};
            16'b0100_0100_1???_?101: hit = '{OP_ADD,   F_SPR2,   1'b0};
            16'b0001_100?_????_????: hit = '{OP_ADD,   F_R3,     1'b1};
            16'b0100_0100_????_????: hit = '{OP_ADD,   F_HI_DNM, 1'b0};
            16'b1010_1???_????_????: hit = '{OP_ADDI,  F_SPI8,   1'b0};
            16'b1011_0000_0???_????: hit = '{OP_ADDI,  F_SPI7,   1'b0};
            16'b1010_0???_????_????: hit = '{OP_ADR,   F_R8I8,   1'b0};
            16'b0100_0000_00??_????: hit = '{OP_AND,   F_DP,     1'b1};
            16'b0001_0???_????_????: hit = '{OP_ASRI,  F_SHI32,  1'b1};
            16'b0100_0001_00??_????: hit = '{OP_ASR,   F_DP,     1'b1};
            16'b1101_1111_????_????: hit = '{OP_SVC,   F_I8,     1'b0};
            16'b1101_1110_????_????: hit = '{OP_UDF,   F_NONE,   1'b0};
            16'b1101_????_????_????: hit = '{OP_BCOND, F_BC,     1'b0};
            16'b1110_0???_????_????: hit = '{OP_BCOND, F_B,      1'b0};
            16'b0100_0011_10??_????: hit = '{OP_BIC,   F_DP,     1'b1};
            16'b1011_1110_????_????: hit = '{OP_BKPT,  F_I8,     1'b0};
            16'b0100_0111_1???_????: hit = '{OP_BLX,   F_M4,     1'b0};
            16'b0100_0111_0???_????: hit = '{OP_BX,    F_M4,     1'b0};
            16'b0100_0010_11??_????: hit = '{OP_CMN,   F_DP,     1'b1};
            16'b0010_1???_????_????: hit = '{OP_CMP,   F_N8I8,   1'b1};
            16'b0100_0010_10??_????: hit = '{OP_CMP,   F_CMPLO,  1'b1};
            16'b0100_0101_????_????: hit = '{OP_CMP,   F_HI_NM,  1'b1};
            16'b0100_0000_01??_????: hit = '{OP_EOR,   F_DP,     1'b1};
            16'b1100_1???_????_????: hit = '{OP_LDM,   F_LIST,   1'b0};
            16'b0110_1???_????_????: hit = '{OP_LDRI,  F_LSI,    1'b0};
            16'b1001_1???_????_????: hit = '{OP_LDRI,  F_SPI8,   1'b0};
            16'b0100_1???_????_????: hit = '{OP_LDRL,  F_R8I8,   1'b0};
            16'b0101_100?_????_????: hit = '{OP_LDR,   F_R3,     1'b0};
            16'b0111_1???_????_????: hit = '{OP_LDRBI, F_LSI,    1'b0};
            16'b0101_110?_????_????: hit = '{OP_LDRB,  F_R3,     1'b0};
            16'b1000_1???_????_????: hit = '{OP_LDRHI, F_LSI,    1'b0};
            16'b0101_101?_????_????: hit = '{OP_LDRH,  F_R3,     1'b0};
            16'b0101_011?_????_????: hit = '{OP_LDRSB, F_R3,     1'b0};
            16'b0101_111?_????_????: hit = '{OP_LDRSH, F_R3,     1'b0};
            16'b0000_0000_00??_????: hit = '{OP_MOV,   F_DM,     1'b1};
            16'b0000_0???_????_????: hit = '{OP_LSLI,  F_SHI,    1'b1};
            16'b0100_0000_10??_????: hit = '{OP_LSL,   F_DP,     1'b1};
            16'b0000_1???_????_????: hit = '{OP_LSRI,  F_SHI32,  1'b1};
            16'b0100_0000_11??_????: hit = '{OP_LSR,   F_DP,     1'b1};
            16'b0010_0???_????_????: hit = '{OP_MOV,   F_R8I8,   1'b1};
            16'b0100_0110_????_????: hit = '{OP_MOV,   F_HI_DM,  1'b0};
            16'b0100_0011_01??_????: hit = '{OP_MUL,   F_DP,     1'b1};
            16'b0100_0011_11??_????: hit = '{OP_MVN,   F_DP,     1'b1};
            16'b1011_1111_0000_0000: hit = '{OP_NOP,   F_NONE,   1'b0};
            16'b0100_0011_00??_????: hit = '{OP_ORR,   F_DP,     1'b1};
            16'b1011_110?_????_????: hit = '{OP_POP,   F_POP,    1'b0};
            16'b1011_010?_????_????: hit = '{OP_PUSH,  F_PUSH,   1'b0};
            16'b1011_1010_00??_????: hit = '{OP_REV,   F_DM,     1'b0};
            16'b1011_1010_01??_????: hit = '{OP_REV16, F_DM,     1'b0};
            16'b1011_1010_11??_????: hit = '{OP_REVSH, F_DM,     1'b0};
            16'b0100_0001_11??_????: hit = '{OP_ROR,   F_DP,     1'b1};
            16'b0100_0010_01??_????: hit = '{OP_RSB,   F_DP,     1'b1};
            16'b0100_0001_10??_????: hit = '{OP_SBC,   F_DP,     1'b1};
            16'b1011_1111_0100_0000: hit = '{OP_SEV,   F_NONE,   1'b0};
            16'b1100_0???_????_????: hit = '{OP_STM,   F_LIST,   1'b0};
            16'b0110_0???_????_????: hit = '{OP_STRI,  F_LSI,    1'b0};
            16'b1001_0???_????_????: hit = '{OP_STRI,  F_SPI8,   1'b0};
            16'b0101_000?_????_????: hit = '{OP_STR,   F_R3,     1'b0};
            16'b0111_0???_????_????: hit = '{OP_STRBI, F_LSI,    1'b0};
            16'b0101_010?_????_????: hit = '{OP_STRB,  F_R3,     1'b0};
            16'b1000_0???_????_????: hit = '{OP_STRHI, F_LSI,    1'b0};
            16'b0101_001?_????_????: hit = '{OP_STRH,  F_R3,     1'b0};
            16'b0001_111?_????_????: hit = '{OP_SUBI,  F_I3,     1'b1};
            16'b0011_1???_????_????: hit = '{OP_SUBI,  F_DN8I8,  1'b1};
            16'b0001_101?_????_????: hit = '{OP_SUB,   F_R3,     1'b1};
            16'b1011_0000_1???_????: hit = '{OP_SUB,   F_SPI7,   1'b0};
            16'b1011_0010_01??_????: hit = '{OP_SXTB,  F_DM,     1'b0};
            16'b1011_0010_00??_????: hit = '{OP_SXTH,  F_DM,     1'b0};
            16'b0100_0010_00??_????: hit = '{OP_TST,   F_DP,     1'b1};
            16'b1011_0010_11??_????: hit = '{OP_UXTB,  F_DM,     1'b0};
            16'b1011_0010_10??_????: hit = '{OP_UXTH,  F_DM,     1'b0};
            16'b1011_1111_0010_0000: hit = '{OP_WFE,   F_NONE,   1'b0};
            16'b1011_1111_0011_0000: hit = '{OP_WFI,   F_NONE,   1'b0};
            16'b1011_1111_0001_0000: hit = '{OP_YIELD, F_NONE,   1'b0};
            default:                 hit = '{OP_UDF,   F_NONE,   1'b0};
        endcase

        r0 = {1'b0, h[2:0]};
        r3 = {1'b0, h[5:3]};
        r6 = {1'b0, h[8:6]};
        r8 = {1'b0, h[10:8]};
        n4 = {h[7], h[2:0]};
        m4 = h[6:3];
        i5 = {20'b0, h[10:6]};
        i8 = {17'b0, h[7:0]};
        d.op = hit.op;
        d.sf = hit.sf;
        case (hit.form)
            F_DP: begin
                d.rd = r0; d.rn = r0; d.rm = r3;
            end
            F_R3: begin
                d.rd = r0; d.rn = r3; d.rm = r6;
            end
            F_I3: begin
                d.rd = r0; d.rn = r3; d.imm = {21'b0, r6};
            end
            F_SHI: begin
                d.rd = r0; d.rm = r3; d.imm = i5;
            end
            F_SHI32: begin
                // encoded shift of zero means 32
                d.rd = r0; d.rm = r3; d.imm = (h[10:6] == 5'd0) ? 25'd32 : i5;
            end
            F_LSI: begin
                d.rd = r0; d.rn = r3; d.imm = i5;
            end
            F_R8I8: begin
                d.rd = r8; d.imm = i8;
            end
            F_N8I8: begin
                d.rn = r8; d.imm = i8;
            end
            F_DN8I8: begin
                d.rd = r8; d.rn = r8; d.imm = i8;
            end
            F_SPI8: begin
                d.rd = r8; d.rn = SP_NUM; d.imm = i8;
            end
            F_SPI7: begin
                d.rd = SP_NUM; d.rn = SP_NUM; d.imm = {18'b0, h[6:0]};
            end
            F_HI_DNM: begin
                d.rd = n4; d.rn = n4; d.rm = m4;
            end
            F_HI_NM: begin
                d.rn = n4; d.rm = m4;
            end
            F_HI_DM: begin
                d.rd = n4; d.rm = m4;
            end
            F_CMPLO: begin
                d.rn = r0; d.rm = r3;
            end
            F_DM: begin
                d.rd = r0; d.rm = r3;
            end
            F_SPR: begin
                d.rd = n4; d.rm = n4; d.rn = SP_NUM;
            end
            F_SPR2: begin
                d.rd = SP_NUM; d.rn = SP_NUM; d.rm = m4;
            end
            F_M4:    d.rm = m4;
            F_I8:    d.imm = i8;
            F_LIST: begin
                d.rn = r8; d.spec = {8'b0, h[7:0]};
            end
            F_PUSH:  d.spec = {1'b0, h[8], 6'b0, h[7:0]};
            F_POP:   d.spec = {h[8], 7'b0, h[7:0]};
            F_BC: begin
                d.imm  = {{16{h[7]}}, h[7:0], 1'b0};
                d.spec = {12'b0, h[11:8]};
            end
            F_B: begin
                d.imm  = {{13{h[10]}}, h[10:0], 1'b0};
                d.spec = COND_ALWAYS;
            end
            default: ;
        endcase
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_total++;
        $display("[%0t] %s mismatch: instr %08h wide %0d got %0h expected %0h",
                 $time, what, cur.instr, cur.wide, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                result_total++;
                if (pending_decodes.size() == 0) begin
                    cur = '{instr: '0, wide: 1'b0, want: '0};
                    report_mismatch("unrequested result", i_m_tdata[31:0], 32'd0);
                end else begin
                    cur = pending_decodes.pop_front();
                    if (!ops_hit[cur.want.op]) begin
                        ops_hit[cur.want.op] = 1'b1;
                        ops_total++;
                    end
                    if (i_m_tdata[6:0] !== cur.want.op)
                        report_mismatch("operation", 32'(i_m_tdata[6:0]), 32'(cur.want.op));
                    if (i_m_tdata[10:7] !== cur.want.rd)
                        report_mismatch("dest_reg", 32'(i_m_tdata[10:7]), 32'(cur.want.rd));
                    if (i_m_tdata[14:11] !== cur.want.rn)
                        report_mismatch("first_reg", 32'(i_m_tdata[14:11]), 32'(cur.want.rn));
                    if (i_m_tdata[18:15] !== cur.want.rm)
                        report_mismatch("second_reg", 32'(i_m_tdata[18:15]),
                                        32'(cur.want.rm));
                    if (i_m_tdata[43:19] !== cur.want.imm)
                        report_mismatch("immediate", 32'(i_m_tdata[43:19]),
                                        32'(cur.want.imm));
                    if (i_m_tdata[44] !== cur.want.sf)
                        report_mismatch("sets_flags", 32'(i_m_tdata[44]), 32'(cur.want.sf));
                    if (i_m_tdata[60:45] !== cur.want.spec)
                        report_mismatch("specific", 32'(i_m_tdata[60:45]),
                                        32'(cur.want.spec));
                    if (i_m_tdata[63:61] !== 3'b000)
                        report_mismatch("padding", 32'(i_m_tdata[63:61]), 32'd0);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_decodes.push_back('{instr: i_s_tdata, wide: i_s_tuser,
                                            want: decode_thumb(i_s_tdata, i_s_tuser)});
                request_total++;
                if (i_s_tuser)
                    wide_total++;
            end
        end
        o_fail_count    <= fail_total;
        o_pending       <= pending_decodes.size();
        o_requests      <= request_total;
        o_wide_requests <= wide_total;
        o_results       <= result_total;
        o_ops_seen      <= ops_total;
    end

endmodule

// ----- dv/thumb_instruction_decoder_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// thumb_instruction_decoder_top_tb
// Drives Thumb instructions into the decoder: a directed set of corner
// encodings, then random 16- and 32-bit instructions biased toward the
// dense parts of the encoding space. Both stream sides stall at random,
// with one stall-free stretch and one full drain. The checker beside the
// decoder predicts and compares every result.
// ---------------------------------------------------------------------------
module thumb_instruction_decoder_top_tb;
    import tid_pkg::*;

    localparam int RANDOM_REQUESTS = 1075;
    localparam int DRAIN_CYCLES    = 8;

    // {is_wide, instruction}
    localparam logic [32:0] DIRECTED [25] = '{
        {1'b0, 32'h0000_0000},  // LSL #0 becomes MOV
        {1'b0, 32'hFFFF_FFFF},
        {1'b1, 32'h0000_0000},
        {1'b1, 32'hFFFF_FFFF},
        {1'b0, 32'h0000_1000},  // ASR #0 -> 32
        {1'b0, 32'h0000_0817},  // LSR #0 -> 32
        {1'b0, 32'h0000_DE5A},  // permanently undefined
        {1'b0, 32'h0000_D080},
        {1'b0, 32'h0000_E400},
        {1'b0, 32'h0000_E3FF},
        {1'b0, 32'h0000_446D},  // ADD Rd, SP, Rd
        {1'b0, 32'h0000_448D},  // ADD SP, Rm
        {1'b0, 32'h0000_4481},  // plain high-register ADD
        {1'b0, 32'h0000_421F},  // TST
        {1'b0, 32'hA5A5_BF00},  // narrow with junk in upper half
        {1'b0, 32'h0000_B5FF},  // PUSH with LR
        {1'b0, 32'h0000_BDFF},  // POP with PC
        {1'b1, 32'hF3BF_8F5F},
        {1'b1, 32'hF3BF_8F4F},
        {1'b1, 32'hF3BF_8F6F},
        {1'b1, 32'hF3EF_8F10},
        {1'b1, 32'hF38C_8808},
        {1'b1, 32'hF7F0_AFFF},
        {1'b1, 32'hF7FF_FFFE},  // BL backward
        {1'b1, 32'hF000_F800}   // BL with J2 set
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    int unsigned idle_pct = 33;
    int          fail_count, pending, requests, wide_requests, results, ops_seen;

    always #5 clk = ~clk;

    thumb_instruction_decoder_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata)
    );

    thumb_decode_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_requests      (requests),
        .o_wide_requests (wide_requests),
        .o_results       (results),
        .o_ops_seen      (ops_seen)
    );

    // result sink back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);

    task automatic send_request(input logic [31:0] instr, input logic wide);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= instr;
        s_axis_tuser  <= wide;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial begin
        logic [31:0] r, instr;
        logic        wide;
        int unsigned sel;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[k])
            send_request(DIRECTED[k][31:0], DIRECTED[k][32]);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            idle_pct = (n >= 300 && n < 500) ? 0 : 33;
            if (n == 600) begin
                // hold off until the decoder has drained completely
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            r     = $urandom;
            sel   = $urandom_range(0, 99);
            instr = r;
            wide  = 1'b0;
            if (sel < 35) begin
                // any narrow encoding, upper half is noise
            end else if (sel < 55) begin
                instr[15:10] = 6'b010000;      // data-processing group
            end else if (sel < 62) begin
                instr[15:10] = 6'b010001;      // high-register ops, BX/BLX
            end else if (sel < 68) begin
                instr[15:8] = 8'hBF;           // hints
                if ($urandom_range(0, 3) != 0)
                    instr[3:0] = 4'h0;
                instr[7] = ($urandom_range(0, 3) == 0) ? r[7] : 1'b0;
            end else if (sel < 72) begin
                instr[15:12] = 4'hB;           // misc: SP adjust, push/pop, rev
            end else begin
                wide = 1'b1;
                case ($urandom_range(0, 6))
                    0: instr = {24'hF3BF8F, 4'($urandom_range(3, 7)), r[3:0]};
                    1: instr = {20'hF3EF8, r[11:0]};
                    2: instr = {12'hF38, r[19:16], 8'h88, r[7:0]};
                    3: instr = {12'hF7F, r[19:16], 4'hA, r[11:0]};
                    4, 5: begin
                        instr[31:27] = 5'b11110;
                        instr[15:14] = 2'b11;
                        instr[12]    = 1'b1;
                    end
                    default: ;
                endcase
            end
            send_request(instr, wide);
        end
        s_axis_tvalid <= 1'b0;
        idle_pct = 33;

        @(posedge clk);
        for (int n = 0; n < 2000 && pending != 0; n++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d requests (%0d of them 32-bit), %0d results compared.",
                 requests, wide_requests, results);
        $display("%0d distinct operation codes exercised under random source/sink stalls.",
                 ops_seen);
        if (fail_count == 0 && pending == 0)
            $display("** thumb_instruction_decoder_top: PASSED **");
        else
            $display("** thumb_instruction_decoder_top: FAILED **");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run did not complete in time");
        $display("** thumb_instruction_decoder_top: FAILED **");
        $finish;
    end

endmodule
